// ===== src/ghbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghbp_pkg
// Shared types for the PC/DC global history buffer prefetcher.
// ----------------------------------------------------------------------------
package ghbp_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SEARCH_WAIT,
    ST_HEAD_RD,
    ST_HEAD_WAIT,
    ST_APPEND,
    ST_WALK_RD,
    ST_WALK_WAIT,
    ST_PRED_RD,
    ST_PRED_WAIT,
    ST_DONE,
    ST_OUT
  } ghbp_state_e;

  typedef struct packed {
    logic capture;     // latch request
    logic tag_rd;      // read tag at search index
    logic search_adv;  // advance search index
    logic head_rd;     // read chain head of hit slot
    logic append;      // write index + history
    logic walk_rd;     // read link/address at cur
    logic walk_take;   // capture cur record
    logic pred_rd;     // read predecessor address
    logic pred_take;   // form delta, step
    logic finish;      // form result
  } ghbp_cmd_t;

  typedef struct packed {
    logic search_hit;
    logic search_last;
    logic link_ok;
    logic walk_done;
  } ghbp_sts_t;

endpackage

// ===== src/ghbp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghbp_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface ghbp_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/pc_delta_correlation_prefetcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_delta_correlation_prefetcher
// PC-localized delta-correlation prefetcher over a global history buffer.
// ----------------------------------------------------------------------------
// One request at a time, one result per request. A request reads the index
// entries one by one until a tag hit or the last entry, reads the chain head
// on a hit, appends the access to the history buffer, then walks the chain one
// link at a time (at most MaxWalk links), reading each record and then its
// predecessor through the single-port index and history RAMs. No clearing
// pass: the index fills in order from entry 0, so a fill count reset to zero
// marks the entries that hold a PC. address_limit resets to all ones.
module pc_delta_correlation_prefetcher
  import ghbp_pkg::*;
#(
  parameter int IndexEntries   = 512,
  parameter int HistoryEntries = 1024,
  parameter int MaxWalk        = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  ghbp_if.sink   req,
  ghbp_if.source rsp,
  ghbp_if.sink   cfg
);
  ghbp_cmd_t cmd;
  ghbp_sts_t sts;
  logic        pf_valid;
  logic [31:0] pf_addr;

  assign cfg.ready = 1'b1;
  assign rsp.data  = {pf_valid, pf_addr};

  ghbp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .sts_i(sts), .cmd_o(cmd));

  ghbp_dp #(.IndexEntries(IndexEntries), .HistoryEntries(HistoryEntries),
            .MaxWalk(MaxWalk)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .pc_i(req.data[63:32]), .addr_i(req.data[31:0]),
    .cfg_we_i(cfg.valid), .cfg_data_i(cfg.data[31:0]),
    .pf_valid_o(pf_valid), .pf_addr_o(pf_addr));
endmodule

// ===== src/ghbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghbp_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ghbp_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/ghbp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghbp_ctrl
// Sequencer: tag search, append, chain walk, result hand-off.
// ----------------------------------------------------------------------------
module ghbp_ctrl
  import ghbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ghbp_sts_t sts_i,
  output ghbp_cmd_t cmd_o
);
  ghbp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:        if (in_valid_i) state_d = ST_SEARCH;
      ST_SEARCH:      state_d = ST_SEARCH_WAIT;
      ST_SEARCH_WAIT: begin
        if (sts_i.search_hit) state_d = ST_HEAD_RD;
        else if (sts_i.search_last) state_d = ST_APPEND;
        else state_d = ST_SEARCH;
      end
      ST_HEAD_RD:     state_d = ST_HEAD_WAIT;
      ST_HEAD_WAIT:   state_d = ST_APPEND;
      ST_APPEND:      state_d = ST_WALK_RD;
      ST_WALK_RD:     state_d = ST_WALK_WAIT;
      ST_WALK_WAIT:   state_d = sts_i.link_ok ? ST_PRED_RD : ST_DONE;
      ST_PRED_RD:     state_d = ST_PRED_WAIT;
      ST_PRED_WAIT:   state_d = sts_i.walk_done ? ST_DONE : ST_WALK_RD;
      ST_DONE:        state_d = ST_OUT;
      ST_OUT:         if (out_ready_i) state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_SEARCH:      cmd_o.tag_rd = 1'b1;
      ST_SEARCH_WAIT: cmd_o.search_adv = 1'b1;
      ST_HEAD_RD:     cmd_o.head_rd = 1'b1;
      ST_APPEND:      cmd_o.append = 1'b1;
      ST_WALK_RD:     cmd_o.walk_rd = 1'b1;
      ST_WALK_WAIT:   cmd_o.walk_take = 1'b1;
      ST_PRED_RD:     cmd_o.pred_rd = 1'b1;
      ST_PRED_WAIT:   cmd_o.pred_take = 1'b1;
      ST_DONE:        cmd_o.finish = 1'b1;
      ST_OUT:         out_valid_o = 1'b1;
      default:        cmd_o = '0;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_ready_i) |=> state_q == ST_OUT)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.append |=> state_q == ST_WALK_RD)
    else $error("append not followed by walk");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("accepting while result pending");
endmodule

// ===== src/ghbp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghbp_dp
// Datapath: index table, history buffer, delta registers, bounds check.
// ----------------------------------------------------------------------------
module ghbp_dp
  import ghbp_pkg::*;
#(
  parameter int IndexEntries   = 512,
  parameter int HistoryEntries = 1024,
  parameter int MaxWalk        = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ghbp_cmd_t   cmd_i,
  output ghbp_sts_t   sts_o,
  input  logic [31:0] pc_i,
  input  logic [31:0] addr_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  output logic        pf_valid_o,
  output logic [31:0] pf_addr_o
);
  localparam int IW = $clog2(IndexEntries);
  localparam int HW = $clog2(HistoryEntries);
  localparam int LW = HW + 1;
  localparam int WW = $clog2(MaxWalk + 1);

  logic [31:0] limit_q, pc_q, addr_q;
  logic [IW-1:0] sidx_q, fill_q, slot_q;
  // index fills in FIFO order from entry 0, so entries below the count are valid
  logic [IW:0] fill_cnt_q;
  logic found_q;
  logic [HW-1:0] head_q, cur_q, prv_q;
  logic [LW-1:0] plink_q;
  logic [WW-1:0] step_q;
  logic [31:0] cur_addr_q, d_new_q, d_mid_q, d_old_q, cmp0_q, cmp1_q;
  logic hit_q;

  // memories
  logic [IW-1:0] ix_addr;
  logic [31:0] tag_rd;
  logic [HW-1:0] head_rd, h_addr;
  logic [31:0] ha_rd;
  logic [LW-1:0] hl_rd;
  logic ix_we, tag_we;

  assign ix_we  = cmd_i.append;
  assign tag_we = cmd_i.append && !found_q;
  assign ix_addr = (cmd_i.append || cmd_i.head_rd) ? slot_q : sidx_q;
  assign h_addr = cmd_i.append ? head_q + HW'(1) :
                  cmd_i.pred_rd ? prv_q : cur_q;

  logic [HW-1:0] new_head;
  assign new_head = (head_q == HW'(HistoryEntries - 1)) ? '0 : head_q + HW'(1);

  ghbp_ram #(.Width(32), .Depth(IndexEntries)) u_tags (
    .clk_i, .we_i(tag_we), .addr_i(ix_addr), .wdata_i(pc_q), .rdata_o(tag_rd));
  ghbp_ram #(.Width(HW), .Depth(IndexEntries)) u_heads (
    .clk_i, .we_i(ix_we), .addr_i(ix_addr), .wdata_i(new_head), .rdata_o(head_rd));
  ghbp_ram #(.Width(32), .Depth(HistoryEntries)) u_haddr (
    .clk_i, .we_i(cmd_i.append), .addr_i(cmd_i.append ? new_head : h_addr),
    .wdata_i(addr_q), .rdata_o(ha_rd));
  ghbp_ram #(.Width(LW), .Depth(HistoryEntries)) u_hlink (
    .clk_i, .we_i(cmd_i.append), .addr_i(cmd_i.append ? new_head : h_addr),
    .wdata_i(plink_q), .rdata_o(hl_rd));

  logic [IW-1:0] fill_next;
  assign fill_next = (fill_q == IW'(IndexEntries - 1)) ? '0 : fill_q + IW'(1);

  logic [31:0] delta;
  assign delta = cur_addr_q - ha_rd;

  assign sts_o.search_hit  = ({1'b0, sidx_q} < fill_cnt_q) && (tag_rd == pc_q);
  assign sts_o.search_last = (sidx_q == IW'(IndexEntries - 1));
  assign sts_o.link_ok     = (hl_rd != '0) && ({1'b0, hl_rd} <= (LW + 1)'(HistoryEntries));
  assign sts_o.walk_done   = (step_q >= WW'(2)) && (delta == cmp1_q) && (d_new_q == cmp0_q)
                             || (step_q == WW'(MaxWalk - 1));

  logic [32:0] cand;
  assign cand = {1'b0, addr_q} + {{1{d_old_q[31]}}, d_old_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= '1;
      fill_cnt_q <= '0;
      fill_q     <= IW'(IndexEntries - 1);
      head_q     <= HW'(HistoryEntries - 1);
      pf_valid_o <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      if (cmd_i.append) begin
        head_q <= new_head;
        if (!found_q) begin
          if (fill_cnt_q != (IW + 1)'(IndexEntries)) fill_cnt_q <= fill_cnt_q + (IW + 1)'(1);
          fill_q <= fill_next;
        end
      end
      if (cmd_i.capture) hit_q <= 1'b0;
      if (cmd_i.pred_take && (step_q >= WW'(2)) && (delta == cmp1_q) && (d_new_q == cmp0_q))
        hit_q <= 1'b1;
      if (cmd_i.finish) begin
        pf_valid_o <= hit_q && !cand[32] && (cand[31:0] < limit_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pc_q <= pc_i; addr_q <= addr_i; sidx_q <= '0; found_q <= 1'b0;
      plink_q <= '0; step_q <= '0;
      d_new_q <= '0; d_mid_q <= '0; d_old_q <= '0; cmp0_q <= '0; cmp1_q <= '0;
    end
    if (cmd_i.search_adv) begin
      if (sts_o.search_hit) begin
        found_q <= 1'b1; slot_q <= sidx_q;
      end else begin
        sidx_q <= sidx_q + IW'(1);
        if (sts_o.search_last) slot_q <= fill_next;
      end
    end
    if (cmd_i.head_rd) plink_q <= '0;
    if (found_q && !cmd_i.append && !cmd_i.head_rd && !cmd_i.search_adv && plink_q == '0
        && !cmd_i.walk_rd && !cmd_i.walk_take && !cmd_i.pred_rd && !cmd_i.pred_take
        && !cmd_i.finish && !cmd_i.capture)
      plink_q <= {1'b0, head_rd} + LW'(1);
    if (cmd_i.append) cur_q <= new_head;
    if (cmd_i.walk_take) begin
      cur_addr_q <= ha_rd;
      prv_q <= HW'(hl_rd - LW'(1));
    end
    if (cmd_i.pred_take) begin
      d_old_q <= d_mid_q; d_mid_q <= d_new_q; d_new_q <= delta;
      cur_q <= prv_q;
      step_q <= step_q + WW'(1);
      if (step_q == WW'(0)) cmp0_q <= delta;
      if (step_q == WW'(1)) cmp1_q <= delta;
    end
    if (cmd_i.finish) pf_addr_o <= (hit_q && !cand[32] && (cand[31:0] < limit_q))
                                   ? cand[31:0] : '0;
  end
endmodule

// ===== bench/pc_delta_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_delta_tb_pkg
// Request and result layouts shared by the prefetcher testbench modules.
// ----------------------------------------------------------------------------
package pc_delta_tb_pkg;

  typedef struct packed {
    logic [31:0] program_counter;
    logic [31:0] access_address;
  } access_req_t;

  typedef struct packed {
    logic        prefetch_valid;
    logic [31:0] prefetch_address;
  } prefetch_rsp_t;

  typedef logic [31:0] limit_word_t;

endpackage

// ===== bench/pc_delta_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_delta_checker
// Watches the access, prefetch and limit channels, tracks the index table and
// history buffer, and checks every prefetch result in order.
// ----------------------------------------------------------------------------
module pc_delta_checker
  import pc_delta_tb_pkg::*;
#(
  parameter int IndexEntries   = 512,
  parameter int HistoryEntries = 1024,
  parameter int MaxWalk        = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  access_req_t   req_data_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_ready_i,
  input  prefetch_rsp_t rsp_data_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_i,
  input  limit_word_t   cfg_data_i,
  output int            errors_o,
  output int            pending_o,
  output int            accesses_o,
  output int            prefetches_o
);

  logic [31:0] limit_q;
  logic [31:0] tags   [IndexEntries];
  logic        tag_ok [IndexEntries];
  int unsigned heads  [IndexEntries];
  int unsigned fill_slot;
  logic [31:0] hist_addr [HistoryEntries];
  int unsigned hist_link [HistoryEntries];
  int unsigned hist_head;
  prefetch_rsp_t expected_q[$];

  function automatic prefetch_rsp_t next_prefetch(access_req_t a);
    int unsigned slot, prev_link, cur, link, prv;
    bit found, hit;
    logic [31:0] d_new, d_mid, d_old, cmp0, cmp1, delta;
    longint cand;
    prefetch_rsp_t r;
    found = 0; hit = 0; slot = 0; prev_link = 0;
    d_new = 0; d_mid = 0; d_old = 0; cmp0 = 0; cmp1 = 0;
    for (int i = 0; i < IndexEntries; i++) begin
      if (!found && tag_ok[i] && tags[i] == a.program_counter) begin
        found = 1;
        slot = i;
      end
    end
    if (found) begin
      prev_link = heads[slot] % HistoryEntries + 1;
    end else begin
      fill_slot = (fill_slot + 1 >= IndexEntries) ? 0 : fill_slot + 1;
      slot = fill_slot;
      tags[slot] = a.program_counter;
      tag_ok[slot] = 1;
    end
    hist_head = (hist_head + 1 >= HistoryEntries) ? 0 : hist_head + 1;
    hist_addr[hist_head] = a.access_address;
    hist_link[hist_head] = prev_link;
    heads[slot] = hist_head;
    cur = hist_head;
    for (int i = 0; i < MaxWalk; i++) begin
      link = hist_link[cur];
      if (link == 0 || link > HistoryEntries) break;
      prv = link - 1;
      delta = hist_addr[cur] - hist_addr[prv];
      d_old = d_mid;
      d_mid = d_new;
      d_new = delta;
      cur = prv;
      if (i == 0) cmp0 = delta;
      else if (i == 1) cmp1 = delta;
      else if (d_new == cmp1 && d_mid == cmp0) begin
        hit = 1;
        break;
      end
    end
    r = '0;
    if (hit) begin
      cand = longint'({32'b0, a.access_address}) + longint'(signed'(d_old));
      if (cand >= 0 && cand < longint'({32'b0, limit_q})) begin
        r.prefetch_valid = 1'b1;
        r.prefetch_address = cand[31:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    prefetch_rsp_t want;
    if (!rst_ni) begin
      limit_q = '1;
      for (int i = 0; i < IndexEntries; i++) tag_ok[i] = 0;
      fill_slot = IndexEntries - 1;
      hist_head = HistoryEntries - 1;
      expected_q.delete();
      errors_o = 0;
      accesses_o = 0;
      prefetches_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) limit_q = cfg_data_i;
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", rsp_data_i.prefetch_address, 32'h0);
        end else begin
          want = expected_q.pop_front();
          if (rsp_data_i.prefetch_valid !== want.prefetch_valid)
            report_mismatch("prefetch_valid", 32'(rsp_data_i.prefetch_valid),
                            32'(want.prefetch_valid));
          if (rsp_data_i.prefetch_address !== want.prefetch_address)
            report_mismatch("prefetch_address", rsp_data_i.prefetch_address,
                            want.prefetch_address);
          if (want.prefetch_valid) prefetches_o++;
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_q.push_back(next_prefetch(req_data_i));
        accesses_o++;
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== bench/pc_delta_correlation_prefetcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_delta_correlation_prefetcher_tb
// Drives access streams with repeating per-PC stride patterns, noise and fresh
// PCs into the prefetcher, steps the address limit through its extremes, and
// lets the checker compare each prefetch result.
// ----------------------------------------------------------------------------
module pc_delta_correlation_prefetcher_tb;
  import pc_delta_tb_pkg::*;

  localparam int  RandomAccesses = 880;
  localparam int  DrainCycles    = 1600;  // idle wait after the last result drains
  localparam longint CycleLimit  = 6000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ghbp_if #(.T(access_req_t))   req ();
  ghbp_if #(.T(prefetch_rsp_t)) rsp ();
  ghbp_if #(.T(limit_word_t))   cfg ();

  int errors, pending, accesses, prefetches;
  bit calm_tail = 0;   // no idling in the last stretch
  longint cycles = 0;

  pc_delta_correlation_prefetcher DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req),
    .rsp   (rsp),
    .cfg   (cfg)
  );

  pc_delta_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_i (req.ready),
    .req_data_i  (req.data),
    .rsp_valid_i (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .rsp_data_i  (rsp.data),
    .cfg_valid_i (cfg.valid),
    .cfg_ready_i (cfg.ready),
    .cfg_data_i  (cfg.data),
    .errors_o    (errors),
    .pending_o   (pending),
    .accesses_o  (accesses),
    .prefetches_o(prefetches)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Run guard: a hung handshake ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random back-pressure bursts, switched off for the tail.
  initial begin
    int n;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        rsp.ready = 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        rsp.ready = 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_access(logic [31:0] pc, logic [31:0] addr);
    int n;
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      req.valid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    req.valid = 1'b1;
    req.data  = '{program_counter: pc, access_address: addr};
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
  endtask

  task automatic idle_req();
    req.valid = 1'b0;
    @(negedge clk_i);
  endtask

  // Limit writes only with nothing in flight; pending counts accepted requests
  // whose result has not yet been taken, and a further idle wait follows.
  task automatic write_limit(limit_word_t value);
    idle_req();
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.data  = value;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic stride_run(logic [31:0] pc, logic [31:0] start, logic [31:0] step, int n);
    logic [31:0] a;
    a = start;
    for (int i = 0; i < n; i++) begin
      send_access(pc, a);
      a = a + step;
    end
  endtask

  // Hot streams: each PC repeats a pattern of one to three deltas.
  logic [31:0] hot_pc   [8];
  logic [31:0] hot_addr [8];
  logic [31:0] hot_delta[8][3];
  int          hot_len  [8];
  int          hot_pos  [8];

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 512)) - 256);
      default: return 32'($urandom_range(1, 16)) << 2;
    endcase
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 64);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  task automatic reseed_stream(int s);
    hot_pc[s]   = $urandom;
    hot_addr[s] = pick_base();
    hot_len[s]  = $urandom_range(1, 3);
    hot_pos[s]  = 0;
    for (int k = 0; k < 3; k++) hot_delta[s][k] = pick_delta();
  endtask

  task automatic random_phase(int n);
    int s, r;
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(0, 7);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // well-formed: next address of the stream's delta pattern
        hot_addr[s] = hot_addr[s] + hot_delta[s][hot_pos[s]];
        hot_pos[s]  = (hot_pos[s] + 1) % hot_len[s];
        send_access(hot_pc[s], hot_addr[s]);
      end else if (r < 80) begin
        send_access(hot_pc[s], $urandom);           // breaks the pattern
      end else if (r < 97) begin
        send_access($urandom, $urandom);            // fresh PC, pushes index FIFO
      end else begin
        reseed_stream(s);
      end
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.data  = '0;
    cfg.valid = 1'b0;
    cfg.data  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: short chains, constant strides, bounds at both ends, PC extremes.
    stride_run(32'h0000_0000, 32'h0000_1000, 32'd4, 6);
    stride_run(32'hFFFF_FFFF, 32'h0000_0010, 32'hFFFF_FFFC, 6);   // goes below zero
    stride_run(32'h8000_0000, 32'hFFFF_FFE0, 32'd8, 6);            // hits the top
    send_access(32'h5555_AAAA, 32'h0000_0100);                     // alternating +8/-4
    send_access(32'h5555_AAAA, 32'h0000_0108);
    send_access(32'h5555_AAAA, 32'h0000_0104);
    send_access(32'h5555_AAAA, 32'h0000_010C);
    send_access(32'h5555_AAAA, 32'h0000_0108);
    send_access(32'h5555_AAAA, 32'h0000_0110);

    write_limit(32'h0000_0000);                   // nothing may pass
    stride_run(32'h0000_0000, 32'h0000_1018, 32'd4, 3);
    write_limit(32'h0000_1030);                   // candidates right at the limit
    stride_run(32'h0000_0000, 32'h0000_1024, 32'd4, 4);

    for (int s = 0; s < 8; s++) reseed_stream(s);
    write_limit($urandom);
    random_phase(RandomAccesses / 4);
    write_limit(32'h8000_0000);
    random_phase(RandomAccesses / 4);
    write_limit(32'hFFFF_FFFF);
    random_phase(RandomAccesses / 4);
    calm_tail = 1;
    random_phase(RandomAccesses - 3 * (RandomAccesses / 4));
    idle_req();

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    $display("Run covered %0d accesses under five address limits; %0d prefetches proposed.",
             accesses, prefetches);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
